FILE: design/pixu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pixu_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_LENGTHS,
        PH_WRITABLE,
        PH_READONLY,
        PH_IDLE
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BACK_SEEK = 2'd1;
    localparam status_t ST_KEY_LONG  = 2'd2;
    localparam status_t ST_EMPTY_KEY = 2'd3;

    localparam logic [31:0] INFO_OFFSET_BASE = 32'd8;
    localparam logic [31:0] INFO_LAST_OFFSET = 32'd11;
    localparam logic [31:0] MIN_INFO_LENGTH  = 32'd4;
    localparam logic [2:0]  LENGTHS_LAST     = 3'd7;
    localparam logic [7:0]  INVERT_MASK      = 8'hff;

endpackage

`default_nettype wire

FILE: design/packed_image_xor_unscrambler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Each result is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one byte per cycle while the master side is ready; each read-only byte needs one key RAM read.
// The key RAM read is issued at acceptance and its registered data feeds the XOR.
// Reset: rst_n clears the parser control state and the output valid flag at once.
// The key RAM is not cleared; each entry is written before it is read within an image.
module packed_image_xor_unscrambler_unit
    import pixu_pkg::*;
#(
    parameter int KEY_DEPTH = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] image_byte
    input  wire logic        s_tuser,   // [0] image_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] plain_byte, [9:8] status, [15:10] zero
    output logic             m_tuser,   // [0] section
    output logic             m_tlast    // image_done
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [31:0] KEY_DEPTH_W = 32'(KEY_DEPTH);

    phase_t      phase_reg, phase_next, ph_e;
    logic [31:0] off_reg, off_next, off_e;
    logic [32:0] skip_reg, skip_next, skip_e;
    logic [31:0] rl_reg, rl_next, rl_e;
    logic [31:0] wl_reg, wl_next, wl_e;
    logic [31:0] sc_reg, sc_next, sc_e;
    logic [AW-1:0] kp_reg, kp_next, kp_e;
    logic [2:0]  lc_reg, lc_next, lc_e;

    logic        accept;
    logic [31:0] info_full;
    logic [31:0] wl_full;
    logic        wr_last;
    logic        ro_last;
    logic        kp_wrap;
    logic        key_long;
    logic        key_empty;
    logic        hdr_last;

    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_ro;
    logic        res_done;
    status_t     res_status;
    logic        ram_we;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_ro_reg;
    logic        out_done_reg;
    status_t     out_status_reg;
    logic [7:0]  ram_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    // A start mark restarts parsing before the byte is interpreted.
    always_comb
    begin
        if (s_tuser)
        begin
            ph_e   = PH_HEADER;
            off_e  = '0;
            skip_e = '0;
            rl_e   = '0;
            wl_e   = '0;
            sc_e   = '0;
            kp_e   = '0;
            lc_e   = '0;
        end
        else
        begin
            ph_e   = phase_reg;
            off_e  = off_reg;
            skip_e = skip_reg;
            rl_e   = rl_reg;
            wl_e   = wl_reg;
            sc_e   = sc_reg;
            kp_e   = kp_reg;
            lc_e   = lc_reg;
        end
        if (ph_e == PH_SKIP && {1'b0, off_e} == skip_e)
        begin
            ph_e = PH_LENGTHS;
        end
    end

    assign info_full = {s_tdata, skip_e[31:8]};
    assign wl_full   = {s_tdata, wl_e[31:8]};
    assign hdr_last  = (off_e == INFO_LAST_OFFSET);
    assign wr_last   = (sc_e + 32'd1) >= wl_e;
    assign ro_last   = (sc_e + 32'd1) >= rl_e;
    assign kp_wrap   = ({{(32 - AW){1'b0}}, kp_e} + 32'd1) >= wl_e;
    assign key_long  = wl_full > KEY_DEPTH_W;
    assign key_empty = (wl_full == 32'd0) && (rl_e != 32'd0);

    always_comb
    begin
        phase_next = phase_reg;
        off_next   = off_reg;
        skip_next  = skip_reg;
        rl_next    = rl_reg;
        wl_next    = wl_reg;
        sc_next    = sc_reg;
        kp_next    = kp_reg;
        lc_next    = lc_reg;
        if (accept)
        begin
            phase_next = ph_e;
            off_next   = off_e + 32'd1;
            skip_next  = skip_e;
            rl_next    = rl_e;
            wl_next    = wl_e;
            sc_next    = sc_e;
            kp_next    = kp_e;
            lc_next    = lc_e;
            unique case (ph_e)
                PH_HEADER:
                begin
                    if (off_e[31:2] == INFO_OFFSET_BASE[31:2])
                    begin
                        skip_next[31:0] = info_full;
                    end
                    if (hdr_last)
                    begin
                        skip_next = {1'b0, info_full} + 33'd8;
                        if (info_full < MIN_INFO_LENGTH)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (info_full == MIN_INFO_LENGTH)
                        begin
                            phase_next = PH_LENGTHS;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_LENGTHS:
                begin
                    if (!lc_e[2])
                    begin
                        rl_next = {s_tdata, rl_e[31:8]};
                    end
                    else
                    begin
                        wl_next = wl_full;
                    end
                    lc_next = lc_e + 3'd1;
                    if (lc_e == LENGTHS_LAST)
                    begin
                        sc_next = '0;
                        kp_next = '0;
                        if (key_long || key_empty)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (wl_full != 32'd0)
                        begin
                            phase_next = PH_WRITABLE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_WRITABLE:
                begin
                    sc_next = sc_e + 32'd1;
                    if (wr_last)
                    begin
                        sc_next    = '0;
                        kp_next    = '0;
                        phase_next = (rl_e == 32'd0) ? PH_IDLE : PH_READONLY;
                    end
                end
                PH_READONLY:
                begin
                    kp_next = kp_wrap ? '0 : kp_e + AW'(1);
                    sc_next = sc_e + 32'd1;
                    if (ro_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_SKIP, PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res_byte   = '0;
        res_ro     = 1'b0;
        res_done   = 1'b0;
        res_status = ST_OK;
        ram_we     = 1'b0;
        unique case (ph_e)
            PH_HEADER:
            begin
                if (hdr_last && info_full < MIN_INFO_LENGTH)
                begin
                    res_valid  = 1'b1;
                    res_done   = 1'b1;
                    res_status = ST_BACK_SEEK;
                end
            end
            PH_LENGTHS:
            begin
                if (lc_e == LENGTHS_LAST && key_long)
                begin
                    res_valid  = 1'b1;
                    res_done   = 1'b1;
                    res_status = ST_KEY_LONG;
                end
                else if (lc_e == LENGTHS_LAST && key_empty)
                begin
                    res_valid  = 1'b1;
                    res_done   = 1'b1;
                    res_status = ST_EMPTY_KEY;
                end
            end
            PH_WRITABLE:
            begin
                res_valid = 1'b1;
                res_byte  = s_tdata ^ INVERT_MASK;
                res_done  = wr_last && (rl_e == 32'd0);
                ram_we    = 1'b1;
            end
            PH_READONLY:
            begin
                res_valid = 1'b1;
                res_byte  = s_tdata;
                res_ro    = 1'b1;
                res_done  = ro_last;
            end
            PH_SKIP, PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            off_reg       <= '0;
            skip_reg      <= '0;
            rl_reg        <= '0;
            wl_reg        <= '0;
            sc_reg        <= '0;
            kp_reg        <= '0;
            lc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            skip_reg  <= skip_next;
            rl_reg    <= rl_next;
            wl_reg    <= wl_next;
            sc_reg    <= sc_next;
            kp_reg    <= kp_next;
            lc_reg    <= lc_next;
            if (accept)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg   <= res_byte;
            out_ro_reg     <= res_ro;
            out_done_reg   <= res_done;
            out_status_reg <= res_status;
        end
    end

    pixu_key_ram #(
        .DEPTH (KEY_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (sc_e[AW-1:0]),
        .wdata (res_byte),
        .re    (accept),
        .raddr (kp_e),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg,
                       out_ro_reg ? (out_byte_reg ^ ram_rdata) : out_byte_reg};
    assign m_tuser  = out_ro_reg;
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

FILE: design/pixu_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pixu_key_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/pixu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pixu_checker
    import pixu_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled result changed");

    // A waiting request keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("waiting request changed");

    // The input side is never blocked while no result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

    // An error result always ends the image.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9:8] != ST_OK |-> m_tlast)
    else $error("error result without image end");

    // An error result carries a zero byte and the writable section mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9:8] != ST_OK |-> m_tdata[7:0] == 8'd0 && !m_tuser)
    else $error("error result with data");

endmodule

bind packed_image_xor_unscrambler_unit pixu_checker u_pixu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/sv/tb_packed_image_xor_unscrambler_unit.sv
`timescale 1ns / 1ps

module tb_packed_image_xor_unscrambler_unit;
    import pixu_pkg::*;

    localparam int KEY_DEPTH  = 65536;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 8;
    localparam int RANDOM_BYTES = 975;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } image_req_t;

    typedef struct packed {
        logic [7:0] plain;
        status_t    status;
        logic       section;
        logic       done;
    } plain_res_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_CLOGGED
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    wire in_fire  = s_tvalid && s_tready;
    wire out_fire = m_tvalid && m_tready;

    image_req_t pending_reqs[$];
    plain_res_t expected_plain[$];
    int         errors = 0;
    int         queued = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         idle_cycles = 0;
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_mode_left = 0;

    phase_t      img_phase;
    logic [31:0] img_offset;
    logic [32:0] seek_target;
    logic [31:0] ro_len;
    logic [31:0] wr_len;
    logic [31:0] sec_count;
    logic [31:0] key_idx;
    logic [7:0]  key_mem [0:KEY_DEPTH-1];

    packed_image_xor_unscrambler_unit #(
        .KEY_DEPTH(KEY_DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic restart_parse();
        img_phase   = PH_HEADER;
        img_offset  = 32'd0;
        seek_target = 33'd0;
        ro_len      = 32'd0;
        wr_len      = 32'd0;
        sec_count   = 32'd0;
        key_idx     = 32'd0;
    endtask

    task automatic abort_image(input status_t st);
        img_phase = PH_IDLE;
        expected_plain.push_back('{plain: 8'd0, status: st, section: 1'b0, done: 1'b1});
    endtask

    task automatic unscramble_byte(input logic [7:0] b, input logic start);
        logic [31:0] off;
        logic [31:0] pos;
        logic [7:0]  k;
        logic        done;
        if (start)
            restart_parse();
        off = img_offset;
        if (img_phase == PH_SKIP && {1'b0, off} == seek_target)
            img_phase = PH_LENGTHS;
        case (img_phase)
            PH_HEADER:
            begin
                if (off >= INFO_OFFSET_BASE && off <= INFO_LAST_OFFSET)
                    seek_target = seek_target | (33'(b) << (8 * (off - INFO_OFFSET_BASE)));
                if (off == INFO_LAST_OFFSET)
                begin
                    seek_target = seek_target + 33'(INFO_OFFSET_BASE);
                    if (seek_target < 33'(INFO_LAST_OFFSET) + 33'd1)
                        abort_image(ST_BACK_SEEK);
                    else if (seek_target == 33'(INFO_LAST_OFFSET) + 33'd1)
                        img_phase = PH_LENGTHS;
                    else
                        img_phase = PH_SKIP;
                end
            end
            PH_LENGTHS:
            begin
                pos = off - seek_target[31:0];
                if (pos < 32'd4)
                    ro_len = ro_len | (32'(b) << (8 * pos));
                else
                    wr_len = wr_len | (32'(b) << (8 * pos[1:0]));
                if (pos == 32'(LENGTHS_LAST))
                begin
                    sec_count = 32'd0;
                    key_idx   = 32'd0;
                    if (33'(wr_len) > 33'(KEY_DEPTH))
                        abort_image(ST_KEY_LONG);
                    else if (wr_len == 32'd0 && ro_len != 32'd0)
                        abort_image(ST_EMPTY_KEY);
                    else if (wr_len != 32'd0)
                        img_phase = PH_WRITABLE;
                    else
                        img_phase = PH_IDLE;
                end
            end
            PH_WRITABLE:
            begin
                k    = b ^ INVERT_MASK;
                done = 1'b0;
                if (sec_count < 32'(KEY_DEPTH))
                    key_mem[sec_count[15:0]] = k;
                sec_count = sec_count + 32'd1;
                if (sec_count >= wr_len)
                begin
                    sec_count = 32'd0;
                    key_idx   = 32'd0;
                    if (ro_len == 32'd0)
                    begin
                        img_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    else
                        img_phase = PH_READONLY;
                end
                expected_plain.push_back('{plain: k, status: ST_OK, section: 1'b0, done: done});
            end
            PH_READONLY:
            begin
                k    = 8'd0;
                done = 1'b0;
                if (key_idx < 32'(KEY_DEPTH))
                    k = key_mem[key_idx[15:0]];
                if (key_idx + 32'd1 >= wr_len)
                    key_idx = 32'd0;
                else
                    key_idx = key_idx + 32'd1;
                sec_count = sec_count + 32'd1;
                if (sec_count >= ro_len)
                begin
                    img_phase = PH_IDLE;
                    done      = 1'b1;
                end
                expected_plain.push_back('{plain: b ^ k, status: ST_OK, section: 1'b1,
                                           done: done});
            end
            default:
            begin
            end
        endcase
        img_offset = off + 32'd1;
    endtask

    task automatic push_req(input logic [7:0] b, input logic start);
        pending_reqs.push_back('{data: b, start: start});
        queued++;
    endtask

    task automatic add_image(input logic mark, input logic [31:0] info_len,
                             input logic [31:0] ro_l, input logic [31:0] wr_l,
                             input int body, input int trailing);
        int i;
        for (i = 0; i < 8; i++)
            push_req(8'($urandom), (i == 0) ? mark : 1'b0);
        for (i = 0; i < 4; i++)
            push_req(info_len[8*i +: 8], 1'b0);
        if (info_len >= MIN_INFO_LENGTH && info_len < 32'd1000)
        begin
            for (i = 0; i < int'(info_len) - 4; i++)
                push_req(8'($urandom), 1'b0);
            for (i = 0; i < 4; i++)
                push_req(ro_l[8*i +: 8], 1'b0);
            for (i = 0; i < 4; i++)
                push_req(wr_l[8*i +: 8], 1'b0);
            for (i = 0; i < body; i++)
                push_req(8'($urandom), 1'b0);
        end
        for (i = 0; i < trailing; i++)
            push_req(8'($urandom), 1'b0);
    endtask

    // Requests are presented in bursts; a presented request is held until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (in_fire)
                unscramble_byte(s_tdata, s_tuser);
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reqs[0].data;
                    s_tuser  <= pending_reqs[0].start;
                    void'(pending_reqs.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (expected_plain.size() == 0)
                    note_mismatch("result with nothing expected", 32'(m_tdata), 32'd0);
                else
                begin
                    if (m_tdata[7:0] !== expected_plain[0].plain)
                        note_mismatch("plain_byte", 32'(m_tdata[7:0]),
                                      32'(expected_plain[0].plain));
                    if (m_tdata[9:8] !== expected_plain[0].status)
                        note_mismatch("status", 32'(m_tdata[9:8]),
                                      32'(expected_plain[0].status));
                    if (m_tdata[15:10] !== 6'd0)
                        note_mismatch("tdata padding", 32'(m_tdata[15:10]), 32'd0);
                    if (m_tuser !== expected_plain[0].section)
                        note_mismatch("section", 32'(m_tuser), 32'(expected_plain[0].section));
                    if (m_tlast !== expected_plain[0].done)
                        note_mismatch("image_done", 32'(m_tlast), 32'(expected_plain[0].done));
                    void'(expected_plain.pop_front());
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 2));
                rx_mode_left <= $urandom_range(10, 200);
                m_tready     <= 1'b1;
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
                case (rx_mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_CHOPPY:  m_tready <= ($urandom_range(0, 1) == 0);
                    default:    m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire || out_fire)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_packed_image_xor_unscrambler_unit: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int          sel;
        int          body;
        int          len;
        int          i;
        int          rand_base;
        logic [31:0] il;
        logic [31:0] rl;
        logic [31:0] wl;

        restart_parse();

        // The first image carries no start mark and is parsed straight after reset.
        add_image(1'b0, 32'd4, 32'd5, 32'd3, 8, 2);
        add_image(1'b1, 32'd10, 32'd4, 32'd1, 5, 0);
        add_image(1'b1, 32'd0, 32'd1, 32'd1, 0, 3);
        add_image(1'b1, 32'd3, 32'd1, 32'd1, 0, 1);
        add_image(1'b1, 32'd4, 32'd5, 32'd65537, 0, 2);
        add_image(1'b1, 32'd5, 32'd7, 32'hFFFF_FFFF, 0, 1);
        add_image(1'b1, 32'd4, 32'hFFFF_FFFF, 32'd0, 0, 2);
        add_image(1'b1, 32'd6, 32'd0, 32'd0, 0, 3);
        add_image(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 0, 5);
        add_image(1'b1, 32'hFFFF_FFF8, 32'd0, 32'd0, 0, 4);
        add_image(1'b1, 32'd4, 32'd0, 32'd5, 5, 2);
        add_image(1'b1, 32'd8, 32'd10, 32'd4, 6, 0);
        for (i = 0; i < 5; i++)
            push_req(8'($urandom), 1'b0);

        rand_base = queued;
        while (queued - rand_base < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    push_req(8'($urandom), 1'($urandom_range(0, 1)));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    il = $urandom_range(0, 3);
                else if (sel < 12)
                    il = 32'hFFFF_FFF8 + $urandom_range(0, 7);
                else if (sel < 80)
                    il = $urandom_range(4, 12);
                else
                    il = $urandom_range(13, 40);
                sel = $urandom_range(0, 99);
                if (sel < 6)
                    wl = 32'd0;
                else if (sel < 10)
                    wl = $urandom_range(32'hFFFF_FFFF, 32'h0001_0001);
                else
                    wl = $urandom_range(1, 12);
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    rl = 32'd0;
                else if (sel < 20)
                    rl = $urandom;
                else
                    rl = $urandom_range(1, 30);
                len = (wl > 32'd1000) ? 0 : int'(wl);
                len = len + ((rl > 32'd1000) ? $urandom_range(0, 20) : int'(rl));
                body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
                add_image(1'b1, il, rl, wl, body, $urandom_range(0, 3));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_plain.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("tb_packed_image_xor_unscrambler_unit: PASS");
        else
            $display("tb_packed_image_xor_unscrambler_unit: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/pixu_pkg.sv
design/pixu_key_ram.sv
design/packed_image_xor_unscrambler_unit.sv
design/pixu_checker.sv
tb/sv/tb_packed_image_xor_unscrambler_unit.sv
